// File: rtl/rcba_pkg.sv
// Package for the reference-counted block allocator.
// Holds sizes, opcode, status and state types, and the controller/datapath link structs.
// Depends on nothing.
`default_nettype none

package rcba_pkg;

  localparam int unsigned POOL_BLOCKS = 1024;
  localparam int unsigned BLK_W      = $clog2(POOL_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned ID_W       = 10;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned TPB_W      = 9;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned REF_W      = 16;
  localparam int unsigned STEP_W     = $clog2(LEN_W);

  localparam logic [REF_W-1:0] REF_MAX   = {REF_W{1'b1}};
  localparam logic [TPB_W-1:0] TPB_RESET = TPB_W'(16);
  localparam logic [TPB_W-1:0] TPB_MAX   = TPB_W'(256);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADDREF  = 2'd1,
    OP_DROPREF = 2'd2,
    OP_PREP    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOBLK = 2'd1,
    ST_DFREE = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_EVAL,
    S_WRB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic rem_start;
    logic eval;
    logic wr_b;
    logic load_out;
  } rcba_cmd_t;

  typedef struct packed {
    logic rem_done;
    logic need_wr_b;
    logic out_free;
  } rcba_sts_t;

endpackage

`default_nettype wire

// File: rtl/rcba_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on rcba_pkg for widths.
`default_nettype none

module rcba_rem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rcba_pkg::LEN_W-1:0]      dividend_i,
  input  logic [rcba_pkg::TPB_W-1:0]      divisor_i,
  output logic                            done_o,
  output logic [rcba_pkg::SLOT_W-1:0]     rem_o
);

  logic                          busy_q, busy_d;
  logic [rcba_pkg::STEP_W-1:0]   step_q, step_d;
  logic [rcba_pkg::LEN_W-1:0]    dvd_q, dvd_d;
  logic [rcba_pkg::TPB_W-1:0]    rem_q, rem_d;
  logic [rcba_pkg::TPB_W-1:0]    div_q, div_d;
  logic [rcba_pkg::TPB_W-1:0]    trial;

  assign trial  = {rem_q[rcba_pkg::TPB_W-2:0], dvd_q[rcba_pkg::LEN_W-1]};
  assign done_o = busy_q && (step_q == rcba_pkg::STEP_W'(rcba_pkg::LEN_W - 1));
  assign rem_o  = rem_q[rcba_pkg::SLOT_W-1:0];

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[rcba_pkg::LEN_W-2:0], 1'b0};
      rem_d  = (trial >= div_q) ? (trial - div_q) : trial;
      step_d = step_q + rcba_pkg::STEP_W'(1);
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (rem_q < div_q))
    else $error("Remainder is not below the divisor.");

endmodule

`default_nettype wire

// File: rtl/rcba_ctrl.sv
// Controller state machine of the block allocator.
// Sequences accept, remainder, evaluation, second table write and delivery; uses rcba_pkg.
`default_nettype none

module rcba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          opcode_i,
  output logic                in_stall_o,
  input  rcba_pkg::rcba_sts_t sts_i,
  output rcba_pkg::rcba_cmd_t cmd_o
);

  rcba_pkg::state_e state_q, state_d;
  logic             is_prep;

  assign is_prep = (opcode_i == rcba_pkg::OP_PREP);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = is_prep ? rcba_pkg::S_MOD : rcba_pkg::S_EVAL;
        end
      end
      rcba_pkg::S_MOD: begin
        if (sts_i.rem_done) begin
          state_d = rcba_pkg::S_EVAL;
        end
      end
      rcba_pkg::S_EVAL: begin
        state_d = sts_i.need_wr_b ? rcba_pkg::S_WRB : rcba_pkg::S_DONE;
      end
      rcba_pkg::S_WRB: begin
        state_d = rcba_pkg::S_DONE;
      end
      rcba_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          state_d = rcba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rcba_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != rcba_pkg::S_IDLE);
    cmd_o.accept    = (state_q == rcba_pkg::S_IDLE) && in_valid_i;
    cmd_o.rem_start = cmd_o.accept && is_prep;
    cmd_o.eval      = (state_q == rcba_pkg::S_EVAL);
    cmd_o.wr_b      = (state_q == rcba_pkg::S_WRB);
    cmd_o.load_out  = (state_q == rcba_pkg::S_DONE) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rcba_dp.sv
// Datapath of the block allocator: free stack, reference table, counters and result register.
// Driven by rcba_ctrl commands; uses rcba_pkg and rcba_rem.
`default_nettype none

module rcba_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rcba_pkg::rcba_cmd_t                cmd_i,
  output rcba_pkg::rcba_sts_t                sts_o,
  input  logic                               cfg_we_i,
  input  logic [rcba_pkg::TPB_W-1:0]         cfg_wdata_i,
  input  logic [1:0]                         opcode_i,
  input  logic [rcba_pkg::ID_W-1:0]          blk_id_i,
  input  logic [rcba_pkg::LEN_W-1:0]         seq_length_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [rcba_pkg::ID_W-1:0]          result_block_o,
  output logic [rcba_pkg::SLOT_W-1:0]        tok_slot_o,
  output logic                               copy_needed_o,
  output logic [rcba_pkg::ID_W-1:0]          copy_source_o
);

  localparam logic [rcba_pkg::CNT_W-1:0] NUM_C = rcba_pkg::CNT_W'(rcba_pkg::POOL_BLOCKS);

  logic [rcba_pkg::BLK_W-1:0] stk_mem [rcba_pkg::POOL_BLOCKS];
  logic [rcba_pkg::REF_W-1:0] ref_mem [rcba_pkg::POOL_BLOCKS];

  logic [rcba_pkg::TPB_W-1:0] tpb_q;
  logic [rcba_pkg::TPB_W-1:0] tpb_eff;
  logic [rcba_pkg::CNT_W-1:0] count_q;
  logic [rcba_pkg::CNT_W-1:0] fresh_q;
  logic                       out_valid_q;

  rcba_pkg::opcode_e          op_q;
  logic [rcba_pkg::ID_W-1:0]  bid_q;
  logic [rcba_pkg::BLK_W-1:0] bid_idx_q;
  logic [rcba_pkg::BLK_W-1:0] rd_idx;
  logic [rcba_pkg::REF_W-1:0] ref_rd_q;
  logic [rcba_pkg::BLK_W-1:0] stk_rd_q;
  logic [rcba_pkg::REF_W-1:0] wb_data_q;

  rcba_pkg::status_e          res_st_q, res_st_d;
  logic [rcba_pkg::ID_W-1:0]  res_blk_q, res_blk_d;
  logic [rcba_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;
  logic                       res_cp_q, res_cp_d;
  logic [rcba_pkg::ID_W-1:0]  res_src_q, res_src_d;

  rcba_pkg::status_e          out_st_q;
  logic [rcba_pkg::ID_W-1:0]  out_blk_q;
  logic [rcba_pkg::SLOT_W-1:0] out_slot_q;
  logic                       out_cp_q;
  logic [rcba_pkg::ID_W-1:0]  out_src_q;

  logic                       rem_done;
  logic [rcba_pkg::SLOT_W-1:0] rem;

  logic [rcba_pkg::CNT_W-1:0] top_k;
  logic                       pristine;
  logic                       can_pop;
  logic [rcba_pkg::BLK_W-1:0] pop_blk;
  logic [rcba_pkg::ID_W-1:0]  pop_id;
  logic                       ref_ok;
  logic [rcba_pkg::REF_W-1:0] cnt;

  logic                       do_pop;
  logic                       do_push;
  logic                       wa_en;
  logic [rcba_pkg::BLK_W-1:0] wa_addr;
  logic [rcba_pkg::REF_W-1:0] wa_data;
  logic                       wb_en;
  logic [rcba_pkg::REF_W-1:0] wb_data_d;

  logic                       ref_we;
  logic [rcba_pkg::BLK_W-1:0] ref_waddr;
  logic [rcba_pkg::REF_W-1:0] ref_wdata;

  always_comb begin
    if (tpb_q == '0) begin
      tpb_eff = rcba_pkg::TPB_W'(1);
    end else if (tpb_q > rcba_pkg::TPB_MAX) begin
      tpb_eff = rcba_pkg::TPB_MAX;
    end else begin
      tpb_eff = tpb_q;
    end
  end

  rcba_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (seq_length_i),
    .divisor_i  (tpb_eff),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Live stack entries at or above the pool size minus fresh_q have been written; the entries
  // below it still hold their reset contents, and blocks below fresh_q are the only ones ever counted.
  assign top_k    = count_q - rcba_pkg::CNT_W'(1);
  assign rd_idx   = rcba_pkg::BLK_W'(32'(blk_id_i));
  assign pristine = (top_k < (NUM_C - fresh_q));
  assign can_pop  = (count_q != '0);
  assign pop_blk  = pristine ? rcba_pkg::BLK_W'(NUM_C - rcba_pkg::CNT_W'(1) - top_k) : stk_rd_q;
  assign pop_id   = rcba_pkg::ID_W'(32'(pop_blk));
  assign ref_ok   = (32'(bid_q) < 32'(fresh_q));
  assign cnt      = ref_ok ? ref_rd_q : '0;

  always_comb begin
    res_st_d   = rcba_pkg::ST_OK;
    res_blk_d  = '0;
    res_slot_d = '0;
    res_cp_d   = 1'b0;
    res_src_d  = '0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    wa_en      = 1'b0;
    wa_addr    = bid_idx_q;
    wa_data    = '0;
    wb_en      = 1'b0;
    wb_data_d  = '0;
    unique case (op_q)
      rcba_pkg::OP_ALLOC: begin
        if (can_pop) begin
          do_pop    = 1'b1;
          res_blk_d = pop_id;
          wa_en     = 1'b1;
          wa_addr   = pop_blk;
          wa_data   = rcba_pkg::REF_W'(1);
        end else begin
          res_st_d = rcba_pkg::ST_NOBLK;
        end
      end
      rcba_pkg::OP_ADDREF: begin
        res_blk_d = bid_q;
        if (cnt == '0) begin
          res_st_d = rcba_pkg::ST_DFREE;
        end else if (cnt == rcba_pkg::REF_MAX) begin
          res_st_d = rcba_pkg::ST_SAT;
        end else begin
          wa_en   = 1'b1;
          wa_data = cnt + rcba_pkg::REF_W'(1);
        end
      end
      rcba_pkg::OP_DROPREF: begin
        res_blk_d = bid_q;
        if (cnt == '0) begin
          res_st_d = rcba_pkg::ST_DFREE;
        end else begin
          wa_en   = 1'b1;
          wa_data = cnt - rcba_pkg::REF_W'(1);
          do_push = (cnt == rcba_pkg::REF_W'(1));
        end
      end
      rcba_pkg::OP_PREP: begin
        if (rem == '0) begin
          if (can_pop) begin
            do_pop    = 1'b1;
            res_blk_d = pop_id;
            wa_en     = 1'b1;
            wa_addr   = pop_blk;
            wa_data   = rcba_pkg::REF_W'(1);
          end else begin
            res_st_d = rcba_pkg::ST_NOBLK;
          end
        end else if (cnt > rcba_pkg::REF_W'(1)) begin
          if (can_pop) begin
            do_pop     = 1'b1;
            res_blk_d  = pop_id;
            res_slot_d = rem;
            res_cp_d   = 1'b1;
            res_src_d  = bid_q;
            wa_en      = 1'b1;
            wa_addr    = pop_blk;
            wa_data    = rcba_pkg::REF_W'(1);
            wb_en      = 1'b1;
            wb_data_d  = cnt - rcba_pkg::REF_W'(1);
          end else begin
            res_st_d = rcba_pkg::ST_NOBLK;
          end
        end else begin
          res_blk_d  = bid_q;
          res_slot_d = rem;
        end
      end
      default: begin
        res_st_d = rcba_pkg::ST_OK;
      end
    endcase
  end

  assign ref_we    = (cmd_i.eval && wa_en) || cmd_i.wr_b;
  assign ref_waddr = cmd_i.wr_b ? bid_idx_q : wa_addr;
  assign ref_wdata = cmd_i.wr_b ? wb_data_q : wa_data;

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (cmd_i.accept) begin
      ref_rd_q <= ref_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && do_push && (count_q < NUM_C)) begin
      stk_mem[count_q[rcba_pkg::BLK_W-1:0]] <= bid_idx_q;
    end
    if (cmd_i.accept) begin
      stk_rd_q <= stk_mem[top_k[rcba_pkg::BLK_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q       <= rcba_pkg::TPB_RESET;
      count_q     <= NUM_C;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpb_q <= cfg_wdata_i;
      end
      if (cmd_i.eval) begin
        if (do_pop) begin
          count_q <= count_q - rcba_pkg::CNT_W'(1);
          if (pristine) begin
            fresh_q <= fresh_q + rcba_pkg::CNT_W'(1);
          end
        end else if (do_push && (count_q < NUM_C)) begin
          count_q <= count_q + rcba_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= rcba_pkg::opcode_e'(opcode_i);
      bid_q     <= blk_id_i;
      bid_idx_q <= rd_idx;
    end
    if (cmd_i.eval) begin
      res_st_q   <= res_st_d;
      res_blk_q  <= res_blk_d;
      res_slot_q <= res_slot_d;
      res_cp_q   <= res_cp_d;
      res_src_q  <= res_src_d;
      wb_data_q  <= wb_data_d;
    end
    if (cmd_i.load_out) begin
      out_st_q   <= res_st_q;
      out_blk_q  <= res_blk_q;
      out_slot_q <= res_slot_q;
      out_cp_q   <= res_cp_q;
      out_src_q  <= res_src_q;
    end
  end

  assign sts_o.rem_done  = rem_done;
  assign sts_o.need_wr_b = wb_en;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign result_block_o  = out_blk_q;
  assign tok_slot_o      = out_slot_q;
  assign copy_needed_o   = out_cp_q;
  assign copy_source_o   = out_src_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NUM_C)
    else $error("Free count exceeds the pool size.");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= NUM_C)
    else $error("Handed-out block mark exceeds the pool size.");

  a_copy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cp_q) |-> (out_st_q == rcba_pkg::ST_OK))
    else $error("Copy requested on a failed transaction.");

  a_pop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && do_pop) |=> (count_q == $past(count_q) - rcba_pkg::CNT_W'(1)))
    else $error("Allocation did not lower the free count.");

endmodule

`default_nettype wire

// File: rtl/refcounted_block_allocator_cow.sv
// Top level of the reference-counted block allocator with copy-on-write slot preparation.
// Instantiates rcba_ctrl and rcba_dp; uses rcba_pkg.
//
// One transaction is in work at a time, and one result transaction comes out for each input.
// Allocate, add reference and drop reference go from acceptance to the next acceptance in
// order: the accept cycle reads both tables, the evaluation state evaluates and updates,
// and the delivery state hands the result to the output register once it is free. Prepare
// write first waits for the slot, found by a bit-serial remainder unit that works through
// the sequence length, and when a private copy is made the shared block needs a second
// reference table write. The output register lets a finished result wait while the next transaction is
// taken. No clearing pass follows reset: a mark of blocks ever handed out tells which
// stack and reference entries still hold their reset values.
`default_nettype none

module refcounted_block_allocator_cow (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcba_pkg::TPB_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [rcba_pkg::ID_W-1:0]     blk_id_i,
  input  logic [rcba_pkg::LEN_W-1:0]    seq_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [rcba_pkg::ID_W-1:0]     result_block_o,
  output logic [rcba_pkg::SLOT_W-1:0]   tok_slot_o,
  output logic                          copy_needed_o,
  output logic [rcba_pkg::ID_W-1:0]     copy_source_o
);

  rcba_pkg::rcba_cmd_t cmd;
  rcba_pkg::rcba_sts_t sts;

  rcba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcba_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .blk_id_i        (blk_id_i),
    .seq_length_i    (seq_length_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .result_block_o  (result_block_o),
    .tok_slot_o      (tok_slot_o),
    .copy_needed_o   (copy_needed_o),
    .copy_source_o   (copy_source_o)
  );

endmodule

`default_nettype wire
